// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int VALUE_W  = 32;
  localparam int OCC_W    = 5;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell in the cycle a word is accepted.
  typedef struct packed {
    logic                      insert;  // enqueue that fits
    logic                      remove;  // dequeue from a nonempty queue
    logic signed [VALUE_W-1:0] value;   // value being inserted
  } cell_cmd_t;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a value, compares it with the value
// being inserted and takes its next value from itself, a neighbor or the new value.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                              clk,
  input  spq_pkg::cell_cmd_t                cmd,
  input  logic                              occupied,
  input  logic                              left_gt,
  input  logic signed [spq_pkg::VALUE_W-1:0] left_value,
  input  logic signed [spq_pkg::VALUE_W-1:0] right_value,
  output logic                              gt,
  output logic signed [spq_pkg::VALUE_W-1:0] value
);
  import spq_pkg::*;

  logic signed [VALUE_W-1:0] value_next;

  // A stored entry strictly larger than the new one stays ahead of it.
  assign gt = occupied && (value > cmd.value);

  always_comb begin
    value_next = value;
    if (cmd.insert) begin
      if (!gt) begin
        // first cell that is not larger takes the new value, the rest shift down
        value_next = left_gt ? cmd.value : left_value;
      end
    end else if (cmd.remove) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded max-priority queue kept as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Takes one word per clock: each word is an enqueue (mode 0) or a dequeue of
// the largest value (mode 1) and gives exactly one registered result word in
// the cycle after it is accepted. All CAPACITY cells compare against the
// incoming value in parallel and each loads from itself, a neighbor or the new
// value in the same cycle, so a new word is taken every cycle while the output
// register is free or being drained. An enqueue into a full queue reports
// status full and a dequeue from an empty queue reports status empty; in both
// cases the store is left as it was. Occupancy is the count masked to 5 bits.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic signed [spq_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [spq_pkg::VALUE_W-1:0] out_value,
  output logic [1:0]                         status,
  output logic                               now_empty,
  output logic [spq_pkg::OCC_W-1:0]          occupancy
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             is_full;
  logic             is_empty;
  status_t          status_next;
  cell_cmd_t        cmd;

  logic signed [VALUE_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]       cell_gt;
  logic [CAPACITY-1:0]       cell_occ;

  logic [CNT_W+OCC_W-1:0] occ_wide;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_full  = (count == CAP_CNT);
  assign is_empty = (count == '0);

  always_comb begin
    cmd.insert  = accept && (mode == MODE_ENQ) && !is_full;
    cmd.remove  = accept && (mode == MODE_DEQ) && !is_empty;
    cmd.value   = value;
    count_next  = count;
    status_next = STATUS_OK;
    if (mode == MODE_ENQ) begin
      if (is_full) status_next = STATUS_FULL;
      else         count_next  = count + 1'b1;
    end else begin
      if (is_empty) status_next = STATUS_EMPTY;
      else          count_next  = count - 1'b1;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      l_gt;
    logic signed [VALUE_W-1:0] l_val;
    logic signed [VALUE_W-1:0] r_val;

    assign cell_occ[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      // the head sees an endless larger entry ahead of it
      assign l_gt  = 1'b1;
      assign l_val = value;
    end else begin : g_body
      assign l_gt  = cell_gt[i-1];
      assign l_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_val = cell_val[i];
    end else begin : g_inner
      assign r_val = cell_val[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (cell_occ[i]),
      .left_gt     (l_gt),
      .left_value  (l_val),
      .right_value (r_val),
      .gt          (cell_gt[i]),
      .value       (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result word until it is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_value <= cmd.remove ? cell_val[0] : '0;
      status    <= status_next;
      now_empty <= (count_next == '0);
    end
  end

  assign occ_wide  = {{OCC_W{1'b0}}, count};
  assign occupancy = occ_wide[OCC_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (cell_val[0] >= cell_val[1]))
    else $error("head cells out of order");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == MODE_ENQ) && is_full) |=>
      (out_valid && (status == STATUS_FULL) && $stable(count)))
    else $error("enqueue into full queue not refused");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(count))
    else $error("store changed while result stalled");

endmodule
